// ----- src/rrts_pkg.sv -----
// Types and codes shared by the round robin thread scheduler.
`timescale 1ns / 1ps
package rrts_pkg;
   localparam logic [15:0] SLICE_RESET = 16'd50;
   localparam logic [15:0] FIRST_TID = 16'd1;

   typedef enum logic [2:0] {
      ACT_SPAWN = 3'd0,
      ACT_YIELD = 3'd1,
      ACT_JOIN  = 3'd2,
      ACT_DONE  = 3'd3,
      ACT_TICK  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_DEADLOCK = 2'd2,
      STS_FINISHED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] target_tid;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] running_tid;
      logic [15:0] result_tid;
      logic        switched;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tid;
      logic [15:0] wait_tid;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic live;
   } cell_ctl_type;
endpackage

// ----- src/round_robin_thread_scheduler.sv -----
// Round robin thread scheduler top level: control and the ready and wait queue chains.
// Spawn, yield, tick and unknown events: result registered, in the cycle after the transaction.
// Join: S_SCAN waits while the match bit ripples along the cell chains.
// Done: S_SWEEP moves one wait entry per cycle, then gives the result.
// busy is high while a join or done event is in work; one event in flight at a time.
// Synchronous reset: thread 0 runs, queues empty, next id 1, slice 50.
`timescale 1ns / 1ps
module round_robin_thread_scheduler import rrts_pkg::*; #(
   parameter int MAX_THREADS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   localparam int CW = $clog2(MAX_THREADS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWEEP} state_type;

   state_type      state_ff;
   logic [CW-1:0]  rc_ff, wc_ff, cnt_ff, rem_ff;
   logic [15:0]    running_ff, next_tid_ff, slice_left_ff, slice_ticks_ff, target_ff;
   logic           finished_ff, rsp_valid_ff;
   rsp_type        rsp_ff;

   entry_type      r_q [MAX_THREADS];
   entry_type      w_q [MAX_THREADS];
   logic           r_hit [MAX_THREADS];
   logic           w_hit [MAX_THREADS];

   logic           accept, r_shift, r_load, w_shift, w_load, full, live, slice_end;
   entry_type      r_ld, w_ld;
   logic [CW-1:0]  r_idx, w_idx;
   logic [CW:0]    used;

   assign accept    = start && (state_ff == S_IDLE);
   assign used      = {1'b0, rc_ff} + {1'b0, wc_ff} + (CW + 1)'(1);
   assign full      = used >= (CW + 1)'(MAX_THREADS);
   assign slice_end = slice_left_ff <= 16'd1;
   assign live      = (running_ff == target_ff) || r_hit[MAX_THREADS-1] ||
                      w_hit[MAX_THREADS-1];

   always_comb begin
      r_shift = 1'b0;
      r_load  = 1'b0;
      w_shift = 1'b0;
      w_load  = 1'b0;
      r_ld    = '{tid: running_ff, wait_tid: 16'd0};
      w_ld    = '{tid: running_ff, wait_tid: target_ff};
      case (state_ff)
         S_IDLE: begin
            if (accept && !finished_ff) begin
               case (req_data.action)
                  ACT_SPAWN: begin
                     if (!full) begin
                        r_load = 1'b1;
                        r_ld   = '{tid: next_tid_ff, wait_tid: 16'd0};
                     end
                  end
                  ACT_YIELD: begin
                     if (rc_ff != '0) begin
                        r_shift = 1'b1;
                        r_load  = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (slice_end && rc_ff != '0) begin
                        r_shift = 1'b1;
                        r_load  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (cnt_ff == CW'(MAX_THREADS) && live && rc_ff != '0) begin
               w_load  = 1'b1;
               r_shift = 1'b1;
            end
         end
         S_SWEEP: begin
            if (rem_ff != '0) begin
               w_shift = 1'b1;
               if (w_q[0].wait_tid == running_ff) begin
                  r_load = 1'b1;
                  r_ld   = w_q[0];
               end else begin
                  w_load = 1'b1;
                  w_ld   = w_q[0];
               end
            end else if (rc_ff != '0) begin
               r_shift = 1'b1;
            end
         end
         default: ;
      endcase
      r_idx = r_shift ? rc_ff - CW'(1) : rc_ff;
      w_idx = w_shift ? wc_ff - CW'(1) : wc_ff;
   end

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      cell_ctl_type r_ctl, w_ctl;
      entry_type    r_next, w_next;
      logic         r_hin, w_hin;

      assign r_ctl = '{shift: r_shift, load: r_load && (r_idx == CW'(i)),
                       live: CW'(i) < rc_ff};
      assign w_ctl = '{shift: w_shift, load: w_load && (w_idx == CW'(i)),
                       live: CW'(i) < wc_ff};
      if (i == MAX_THREADS - 1) begin : g_last
         assign r_next = r_ld;
         assign w_next = w_ld;
      end else begin : g_mid
         assign r_next = r_q[i+1];
         assign w_next = w_q[i+1];
      end
      if (i == 0) begin : g_first
         assign r_hin = 1'b0;
         assign w_hin = 1'b0;
      end else begin : g_rest
         assign r_hin = r_hit[i-1];
         assign w_hin = w_hit[i-1];
      end

      rrts_cell u_rcell (
         .clock(clock), .reset(reset), .ctl(r_ctl), .next_data(r_next),
         .load_data(r_ld), .key(target_ff), .hit_in(r_hin),
         .data(r_q[i]), .hit(r_hit[i])
      );
      rrts_cell u_wcell (
         .clock(clock), .reset(reset), .ctl(w_ctl), .next_data(w_next),
         .load_data(w_ld), .key(target_ff), .hit_in(w_hin),
         .data(w_q[i]), .hit(w_hit[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rc_ff          <= '0;
         wc_ff          <= '0;
         cnt_ff         <= '0;
         rem_ff         <= '0;
         running_ff     <= 16'd0;
         next_tid_ff    <= FIRST_TID;
         slice_left_ff  <= SLICE_RESET;
         slice_ticks_ff <= SLICE_RESET;
         target_ff      <= 16'd0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_ff         <= '0;
      end else begin
         if (csr_we) begin
            slice_ticks_ff <= csr_wdata;
         end
         rc_ff <= rc_ff + CW'(r_load) - CW'(r_shift);
         wc_ff <= wc_ff + CW'(w_load) - CW'(w_shift);
         if (r_shift) begin
            running_ff    <= r_q[0].tid;
            slice_left_ff <= slice_ticks_ff;
         end
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  target_ff <= req_data.target_tid;
                  rsp_ff    <= '{status: STS_OK, running_tid: running_ff,
                                 result_tid: 16'd0, switched: 1'b0};
                  if (finished_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{status: STS_FINISHED, running_tid: 16'd0,
                                       result_tid: 16'd0, switched: 1'b0};
                  end else begin
                     case (req_data.action)
                        ACT_SPAWN: begin
                           rsp_valid_ff <= 1'b1;
                           if (full) begin
                              rsp_ff.status <= STS_FULL;
                           end else begin
                              rsp_ff.result_tid <= next_tid_ff;
                              next_tid_ff       <= next_tid_ff + 16'd1;
                           end
                        end
                        ACT_YIELD: begin
                           rsp_valid_ff <= 1'b1;
                           if (r_shift) begin
                              rsp_ff.running_tid <= r_q[0].tid;
                              rsp_ff.switched    <= 1'b1;
                           end
                        end
                        ACT_TICK: begin
                           rsp_valid_ff <= 1'b1;
                           if (slice_end) begin
                              slice_left_ff <= slice_ticks_ff;
                           end else begin
                              slice_left_ff <= slice_left_ff - 16'd1;
                           end
                           if (r_shift) begin
                              rsp_ff.running_tid <= r_q[0].tid;
                              rsp_ff.switched    <= 1'b1;
                           end
                        end
                        ACT_JOIN: begin
                           cnt_ff   <= '0;
                           state_ff <= S_SCAN;
                        end
                        ACT_DONE: begin
                           rem_ff   <= wc_ff;
                           state_ff <= S_SWEEP;
                        end
                        default: begin
                           rsp_valid_ff <= 1'b1;
                        end
                     endcase
                  end
               end
            end
            S_SCAN: begin
               if (cnt_ff == CW'(MAX_THREADS)) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.result_tid <= target_ff;
                  state_ff          <= S_IDLE;
                  if (live && rc_ff == '0) begin
                     rsp_ff.status <= STS_DEADLOCK;
                  end
                  if (r_shift) begin
                     rsp_ff.running_tid <= r_q[0].tid;
                     rsp_ff.switched    <= 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_SWEEP: begin
               if (rem_ff != '0) begin
                  rem_ff <= rem_ff - CW'(1);
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (rc_ff == '0) begin
                     finished_ff <= 1'b1;
                     rsp_ff      <= '{status: STS_FINISHED, running_tid: 16'd0,
                                      result_tid: 16'd0, switched: 1'b1};
                  end else begin
                     rsp_ff <= '{status: STS_OK, running_tid: r_q[0].tid,
                                 result_tid: 16'd0, switched: 1'b1};
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_total: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rc_ff} + {1'b0, wc_ff}) < (CW + 1)'(MAX_THREADS))
      else $error("thread count exceeds slots");
   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !r_load && !w_load && rc_ff == '0)
      else $error("queue activity after all threads finished");
   a_deadlock_stay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STS_DEADLOCK |-> !rsp_ff.switched)
      else $error("deadlock reported with a switch");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && cnt_ff != CW'(MAX_THREADS) |=> !rsp_valid_ff)
      else $error("result during join scan");
`endif
endmodule

// ----- src/rrts_cell.sv -----
// One queue cell: holds a thread entry, shifts toward the head, passes a match bit along.
`timescale 1ns / 1ps
module rrts_cell import rrts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    next_data,
   input  entry_type    load_data,
   input  logic [15:0]  key,
   input  logic         hit_in,
   output entry_type    data,
   output logic         hit
);
   entry_type data_ff, data_in;
   logic      hit_ff, hit_in_nx;

   always_comb begin
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
      hit_in_nx = hit_in | (ctl.live && (data_ff.tid == key));
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in_nx;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;
endmodule

// ----- tb/round_robin_thread_scheduler_tb.sv -----
// Self-checking testbench for the round robin thread scheduler: predictor, driver, monitor.
`timescale 1ns / 1ps
module round_robin_thread_scheduler_tb;
   import rrts_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [1:0] SL_FREE = 2'd0;
   localparam logic [1:0] SL_READY = 2'd1;
   localparam logic [1:0] SL_RUN = 2'd2;
   localparam logic [1:0] SL_WAIT = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   round_robin_thread_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // scheduler shadow state
   logic [15:0] s_slice;
   logic [15:0] s_tid [NSLOT];
   logic [15:0] s_wtgt [NSLOT];
   logic [1:0]  s_st [NSLOT];
   int          s_ring [$];
   int          s_wait [$];
   int          s_run;
   logic [15:0] s_next;
   logic [15:0] s_left;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int errors = 0;
   bit drv_idle_en = 1'b1;
   int drv_gap = 0;
   int watchdog = 0;
   bit start_hold = 1'b0;

   task automatic sched_reset();
      s_slice = SLICE_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         s_tid[i] = '0; s_wtgt[i] = '0; s_st[i] = SL_FREE;
      end
      s_st[0] = SL_RUN;
      s_ring.delete(); s_wait.delete();
      s_run = 0; s_next = FIRST_TID; s_left = SLICE_RESET;
   endtask

   function automatic bit tid_live(logic [15:0] t);
      if (s_tid[s_run] == t) return 1'b1;
      foreach (s_ring[i]) if (s_tid[s_ring[i]] == t) return 1'b1;
      foreach (s_wait[i]) if (s_tid[s_wait[i]] == t) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void sched_run_next();
      s_run = s_ring.pop_front();
      s_st[s_run] = SL_RUN;
      s_left = s_slice;
   endfunction

   function automatic bit sched_yield();
      if (s_ring.size() == 0) return 1'b0;
      s_st[s_run] = SL_READY;
      s_ring.push_back(s_run);
      sched_run_next();
      return 1'b1;
   endfunction

   function automatic rsp_type sched_step(req_type r);
      rsp_type o;
      int f;
      int keep [$];
      logic [15:0] dead;
      o = '0;
      if (s_st[s_run] != SL_RUN) begin
         o.status = STS_FINISHED;
         return o;
      end
      o.status = STS_OK;
      case (r.action)
         ACT_SPAWN: begin
            f = -1;
            for (int i = 0; i < NSLOT; i++) if (f < 0 && s_st[i] == SL_FREE) f = i;
            if (f < 0) o.status = STS_FULL;
            else begin
               s_tid[f] = s_next; s_st[f] = SL_READY; s_ring.push_back(f);
               o.result_tid = s_next; s_next = s_next + 16'd1;
            end
         end
         ACT_YIELD: o.switched = sched_yield();
         ACT_JOIN: begin
            o.result_tid = r.target_tid;
            if (tid_live(r.target_tid)) begin
               if (s_ring.size() == 0) o.status = STS_DEADLOCK;
               else begin
                  s_wtgt[s_run] = r.target_tid; s_st[s_run] = SL_WAIT;
                  s_wait.push_back(s_run);
                  sched_run_next();
                  o.switched = 1'b1;
               end
            end
         end
         ACT_DONE: begin
            dead = s_tid[s_run];
            foreach (s_wait[i]) begin
               if (s_wtgt[s_wait[i]] == dead) begin
                  s_st[s_wait[i]] = SL_READY; s_ring.push_back(s_wait[i]);
               end else keep.push_back(s_wait[i]);
            end
            s_wait = keep;
            s_st[s_run] = SL_FREE;
            o.switched = 1'b1;
            if (s_ring.size() == 0) begin
               o.status = STS_FINISHED;
               return o;
            end
            sched_run_next();
         end
         ACT_TICK: begin
            if (s_left <= 16'd1) begin
               s_left = (s_slice == 0) ? 16'd1 : s_slice;
               o.switched = sched_yield();
            end else s_left = s_left - 16'd1;
         end
         default: ;
      endcase
      o.running_tid = s_tid[s_run];
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!start_hold) begin
            if (drv_gap > 0) drv_gap <= drv_gap - 1;
            else if (pending_reqs.size() > 0) begin
               if (drv_idle_en && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(0, 6);
               else begin
                  req_data <= pending_reqs.pop_front();
                  start_hold = 1'b1;
               end
            end
         end
         start <= start_hold;
      end
   end

   // monitor: accept input, check result
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(sched_step(req_data));
            start_hold = 1'b0;
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status !== rsp_data.status || e.running_tid !== rsp_data.running_tid
                   || e.result_tid !== rsp_data.result_tid
                   || e.switched !== rsp_data.switched) begin
                  $display("%0t: mismatch, expected %h, actual %h", $time, e, rsp_data);
                  errors++;
               end
            end
         end
         if ((start && !busy) || rsp_valid) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("round_robin_thread_scheduler test failed");
            $finish;
         end
      end
   end

   function automatic req_type mk(action_type a, logic [15:0] t);
      req_type r;
      r.action = a; r.target_tid = t;
      return r;
   endfunction

   function automatic logic [15:0] pick_tid();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return s_next - 16'($urandom_range(1, 20));
      if (k < 9) return s_next + 16'($urandom_range(0, 3));
      return 16'($urandom);
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || start_hold || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (NSLOT + 8) @(posedge clock);
   endtask

   task automatic write_slice(logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      s_slice = v;
   endtask

   task automatic queue_random(int n);
      int w;
      logic [2:0] a;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(0, 99);
         if (w < 22) a = ACT_SPAWN;
         else if (w < 37) a = ACT_YIELD;
         else if (w < 55) a = ACT_JOIN;
         else if (w < 63) a = ACT_DONE;
         else if (w < 97) a = ACT_TICK;
         else a = 3'($urandom_range(5, 7));
         pending_reqs.push_back(mk(action_type'(a), pick_tid()));
      end
   endtask

   initial begin
      sched_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      write_slice(16'd1);
      pending_reqs.push_back(mk(ACT_JOIN, 16'd0));
      pending_reqs.push_back(mk(ACT_YIELD, 16'hFFFF));
      pending_reqs.push_back(mk(ACT_TICK, 16'd0));
      for (int i = 0; i < 16; i++) pending_reqs.push_back(mk(ACT_SPAWN, 16'd0));
      pending_reqs.push_back(mk(ACT_TICK, 16'd0));
      pending_reqs.push_back(mk(ACT_JOIN, 16'd3));
      pending_reqs.push_back(mk(ACT_JOIN, 16'd1));
      pending_reqs.push_back(mk(ACT_JOIN, 16'd999));
      pending_reqs.push_back(mk(action_type'(3'd7), 16'hFFFF));
      pending_reqs.push_back(mk(ACT_DONE, 16'd0));
      drain();
      write_slice(16'd0);
      pending_reqs.push_back(mk(ACT_TICK, 16'd0));
      pending_reqs.push_back(mk(action_type'(3'd5), 16'd0));
      pending_reqs.push_back(mk(action_type'(3'd6), 16'd0));
      drain();
      // random phases with varied slice lengths
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_slice(16'd2);
            1: write_slice(16'd4);
            2: write_slice(16'hFFFF);
            3: write_slice(16'd3);
            default: write_slice(16'($urandom_range(1, 8)));
         endcase
         if (ph == 5) drv_idle_en = 1'b0;
         queue_random(220);
         drain();
      end
      if (errors == 0) begin
         $display("round_robin_thread_scheduler test passed");
      end else begin
         $display("round_robin_thread_scheduler test failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
src/rrts_pkg.sv
src/rrts_cell.sv
src/round_robin_thread_scheduler.sv
tb/round_robin_thread_scheduler_tb.sv
